// File: hdl/savr_pkg.sv
`timescale 1ns / 1ps

package savr_pkg;

  // Default width of the millisecond time base.
  localparam int TIME_BITS_DEF = 32;

  // Field widths.
  localparam int MAG_W   = 10;
  localparam int SPEED_W = 11;
  localparam int MS_W    = 16;
  localparam int GAIN_W  = 16;
  localparam int VEL_W   = 24;
  localparam int RAMP_W  = SPEED_W + 2;
  localparam int PROD_W  = SPEED_W + GAIN_W + 1;
  localparam int Q_FRAC  = 8;

  // Register port geometry.
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = ADDR_W - 2;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_MAX_SPEED  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SPEED_STEP = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL_INTV = 3'd2;
  localparam logic [IDX_W-1:0] REG_STALL_GAP  = 3'd3;
  localparam logic [IDX_W-1:0] REG_STALL_HOLD = 3'd4;
  localparam logic [IDX_W-1:0] REG_REVERSE    = 3'd5;
  localparam logic [IDX_W-1:0] REG_VEL_GAIN   = 3'd6;

  // Register reset values.
  localparam logic [MAG_W-1:0]  RST_MAX_SPEED  = 10'd300;
  localparam logic [MAG_W-1:0]  RST_SPEED_STEP = 10'd60;
  localparam logic [MS_W-1:0]   RST_ACCEL_INTV = 16'd100;
  localparam logic [MS_W-1:0]   RST_STALL_GAP  = 16'd2000;
  localparam logic [MS_W-1:0]   RST_STALL_HOLD = 16'd2000;
  localparam logic              RST_REVERSE    = 1'b0;
  localparam logic [GAIN_W-1:0] RST_VEL_GAIN   = 16'd18976;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [MAG_W-1:0]  max_speed;
    logic [MAG_W-1:0]  speed_step;
    logic [MS_W-1:0]   accel_interval_ms;
    logic [MS_W-1:0]   stall_gap_ms;
    logic [MS_W-1:0]   stall_hold_ms;
    logic              reverse_dir;
    logic [GAIN_W-1:0] velocity_gain_q8;
  } savr_cfg_t;

  // Per-tick result of the control stage.
  typedef struct packed {
    logic                      wr;
    logic                      stop;
    logic signed [SPEED_W-1:0] speed;
    logic signed [SPEED_W-1:0] target;
  } savr_tick_t;

endpackage

// File: hdl/savr_cfg.sv
`timescale 1ns / 1ps

module savr_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [savr_pkg::ADDR_W-1:0] paddr,
  input  logic [savr_pkg::DATA_W-1:0] pwdata,
  output logic [savr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output savr_pkg::savr_cfg_t        cfg
);
  import savr_pkg::*;

  savr_cfg_t        cfg_r;
  savr_cfg_t        cfg_nxt;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  // Register write decode; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MAX_SPEED:  cfg_nxt.max_speed         = pwdata[MAG_W-1:0];
        REG_SPEED_STEP: cfg_nxt.speed_step        = pwdata[MAG_W-1:0];
        REG_ACCEL_INTV: cfg_nxt.accel_interval_ms = pwdata[MS_W-1:0];
        REG_STALL_GAP:  cfg_nxt.stall_gap_ms      = pwdata[MS_W-1:0];
        REG_STALL_HOLD: cfg_nxt.stall_hold_ms     = pwdata[MS_W-1:0];
        REG_REVERSE:    cfg_nxt.reverse_dir       = pwdata[0];
        REG_VEL_GAIN:   cfg_nxt.velocity_gain_q8  = pwdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed         <= RST_MAX_SPEED;
      cfg_r.speed_step        <= RST_SPEED_STEP;
      cfg_r.accel_interval_ms <= RST_ACCEL_INTV;
      cfg_r.stall_gap_ms      <= RST_STALL_GAP;
      cfg_r.stall_hold_ms     <= RST_STALL_HOLD;
      cfg_r.reverse_dir       <= RST_REVERSE;
      cfg_r.velocity_gain_q8  <= RST_VEL_GAIN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      REG_MAX_SPEED:  prdata = DATA_W'(cfg_r.max_speed);
      REG_SPEED_STEP: prdata = DATA_W'(cfg_r.speed_step);
      REG_ACCEL_INTV: prdata = DATA_W'(cfg_r.accel_interval_ms);
      REG_STALL_GAP:  prdata = DATA_W'(cfg_r.stall_gap_ms);
      REG_STALL_HOLD: prdata = DATA_W'(cfg_r.stall_hold_ms);
      REG_REVERSE:    prdata = DATA_W'(cfg_r.reverse_dir);
      REG_VEL_GAIN:   prdata = DATA_W'(cfg_r.velocity_gain_q8);
      default:        prdata = '0;
    endcase
  end

endmodule

// File: hdl/savr_ctrl.sv
`timescale 1ns / 1ps

module savr_ctrl #(
  parameter int TIME_BITS = savr_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  savr_pkg::savr_cfg_t  cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 stall_pulse,
  input  logic                 button_fwd,
  input  logic                 button_rev,
  output logic                 res_valid,
  input  logic                 res_ready,
  output savr_pkg::savr_tick_t res
);
  import savr_pkg::*;

  // Tick state.
  logic [TIME_BITS-1:0]      now_ms_r, now_ms_nxt;
  logic [TIME_BITS-1:0]      last_stall_r, last_stall_nxt;
  logic [TIME_BITS-1:0]      hold_until_r, hold_until_nxt;
  logic [TIME_BITS-1:0]      last_update_r, last_update_nxt;
  logic                      pending_r, pending_nxt;
  logic signed [SPEED_W-1:0] target_r, target_nxt;
  logic signed [SPEED_W-1:0] speed_r, speed_nxt;

  logic                      valid_r;
  savr_tick_t                res_r;
  savr_tick_t                res_nxt;

  logic                      accept;
  logic                      gap_hit;
  logic                      pend;
  logic                      run;
  logic                      stop;
  logic                      due;
  logic                      upd;
  logic signed [SPEED_W-1:0] mag;
  logic signed [SPEED_W-1:0] plus;
  logic signed [SPEED_W-1:0] target_mid;
  logic signed [SPEED_W-1:0] speed_mid;
  logic signed [RAMP_W-1:0]  step_x;
  logic signed [RAMP_W-1:0]  target_x;
  logic signed [RAMP_W-1:0]  up;
  logic signed [RAMP_W-1:0]  dn;

  assign in_ready  = !valid_r || res_ready;
  assign accept    = in_valid && in_ready;
  assign res_valid = valid_r;
  assign res       = res_r;

  // Time base and stall pulse qualification.
  always_comb begin
    now_ms_nxt     = now_ms_r + TIME_BITS'(1);
    gap_hit        = stall_pulse &&
                     ((now_ms_nxt - last_stall_r) > TIME_BITS'(cfg.stall_gap_ms));
    pend           = pending_r || gap_hit;
    last_stall_nxt = gap_hit ? now_ms_nxt : last_stall_r;
    run            = now_ms_nxt > hold_until_r;
    stop           = run && pend;
    pending_nxt    = stop ? 1'b0 : pend;
    hold_until_nxt = stop ? (now_ms_nxt + TIME_BITS'(cfg.stall_hold_ms)) : hold_until_r;
  end

  // Stall stop or button target selection.
  always_comb begin
    mag        = $signed({1'b0, cfg.max_speed});
    plus       = cfg.reverse_dir ? -mag : mag;
    target_mid = target_r;
    speed_mid  = speed_r;
    if (stop) begin
      target_mid = '0;
      speed_mid  = '0;
    end else if (run) begin
      if (button_fwd && !button_rev && (target_r == '0)) begin
        target_mid = plus;
      end else if (!button_fwd && button_rev && (target_r == '0)) begin
        target_mid = -plus;
      end else if (!button_fwd && !button_rev) begin
        target_mid = '0;
      end
    end
  end

  // Speed ramp toward the target, clamped at the target.
  always_comb begin
    due             = (now_ms_nxt - last_update_r) > TIME_BITS'(cfg.accel_interval_ms);
    step_x          = $signed({{(RAMP_W-MAG_W){1'b0}}, cfg.speed_step});
    target_x        = RAMP_W'(target_mid);
    up              = RAMP_W'(speed_mid) + step_x;
    dn              = RAMP_W'(speed_mid) - step_x;
    upd             = 1'b0;
    speed_nxt       = speed_mid;
    if (due) begin
      if (speed_mid < target_mid) begin
        upd       = 1'b1;
        speed_nxt = (up > target_x) ? target_mid : up[SPEED_W-1:0];
      end else if (speed_mid > target_mid) begin
        upd       = 1'b1;
        speed_nxt = (dn < target_x) ? target_mid : dn[SPEED_W-1:0];
      end
    end
    last_update_nxt = upd ? now_ms_nxt : last_update_r;
    target_nxt      = target_mid;
    res_nxt.wr      = stop || upd;
    res_nxt.stop    = stop;
    res_nxt.speed   = speed_nxt;
    res_nxt.target  = target_mid;
  end

  // State advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r      <= '0;
      last_stall_r  <= '0;
      hold_until_r  <= '0;
      last_update_r <= '0;
      pending_r     <= 1'b0;
      target_r      <= '0;
      speed_r       <= '0;
      valid_r       <= 1'b0;
    end else if (accept) begin
      now_ms_r      <= now_ms_nxt;
      last_stall_r  <= last_stall_nxt;
      hold_until_r  <= hold_until_nxt;
      last_update_r <= last_update_nxt;
      pending_r     <= pending_nxt;
      target_r      <= target_nxt;
      speed_r       <= speed_nxt;
      valid_r       <= 1'b1;
    end else if (res_ready) begin
      valid_r       <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: hdl/savr_vel.sv
`timescale 1ns / 1ps

module savr_vel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [savr_pkg::GAIN_W-1:0] gain,
  input  logic                 res_valid,
  output logic                 res_ready,
  input  savr_pkg::savr_tick_t res,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [47:0]          out_data
);
  import savr_pkg::*;

  logic                      p_valid_r;
  savr_tick_t                p_res_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  spd_x;
  logic signed [PROD_W-1:0]  gain_x;
  logic                      p_ready;

  logic                      o_valid_r;
  logic [47:0]               o_data_r;
  logic [47:0]               o_data_nxt;
  logic                      o_ready;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-Q_FRAC-1:0] quot;
  logic [VEL_W-1:0]          vel;

  assign o_ready   = !o_valid_r || out_ready;
  assign p_ready   = !p_valid_r || o_ready;
  assign res_ready = p_ready;
  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  // Speed times Q8.8 gain.
  always_comb begin
    spd_x    = PROD_W'(res.speed);
    gain_x   = $signed(PROD_W'(gain));
    prod_nxt = spd_x * gain_x;
  end

  // Divide by 256 truncating toward zero, then pack the result beat.
  always_comb begin
    biased     = prod_r[PROD_W-1] ? (prod_r + PROD_W'(255)) : prod_r;
    quot       = biased[PROD_W-1:Q_FRAC];
    vel        = p_res_r.wr ? VEL_W'(quot) : '0;
    o_data_nxt = {p_res_r.stop, p_res_r.target, p_res_r.speed, vel, p_res_r.wr};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_r <= res_valid;
      end
      if (o_ready) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready && res_valid) begin
      p_res_r <= res;
      prod_r  <= prod_nxt;
    end
    if (o_ready && p_valid_r) begin
      o_data_r <= o_data_nxt;
    end
  end

endmodule

// File: hdl/stall_aware_velocity_ramp.sv
`timescale 1ns / 1ps

// Velocity ramp with stall pause, one beat per millisecond tick.
// Input stream: each beat is one tick carrying the stall pulse and the two
// button levels. Output stream: one beat per input beat with the velocity
// write flag, the velocity value, current speed, target speed and the stall
// stop flag. The user sets registers over the APB port only while the block is
// idle; the block itself does not enforce this. A result passes the control
// stage, the multiplier stage and the output register. Throughput: one beat
// per cycle unless the receiver stalls; all tick state is updated in the
// control stage in the cycle the beat is accepted, so the next beat follows
// at once. When the receiver stalls, the pipeline fills and in_tready drops
// only once all three stages hold a beat; nothing is lost or repeated.
// Reset clears the millisecond counter, stall bookkeeping, target and speed,
// empties the pipeline and loads the register defaults.
module stall_aware_velocity_ramp #(
  parameter int TIME_BITS = savr_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // stall_pulse, button_fwd, button_rev
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [47:0]                 out_tdata,  // velocity_write, velocity_value,
                                                  // current_speed, target_speed, stall_stop
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [savr_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [savr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [savr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import savr_pkg::*;

  savr_cfg_t  cfg;
  savr_tick_t tick;
  logic       tick_valid;
  logic       tick_ready;

  // Register file.
  savr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Tick state update.
  savr_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .stall_pulse (in_tdata[0]),
    .button_fwd  (in_tdata[1]),
    .button_rev  (in_tdata[2]),
    .res_valid   (tick_valid),
    .res_ready   (tick_ready),
    .res         (tick)
  );

  // Velocity scaling and output register.
  savr_vel u_vel (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain      (cfg.velocity_gain_q8),
    .res_valid (tick_valid),
    .res_ready (tick_ready),
    .res       (tick),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
